// File: rtl/hdlcf_pkg.sv
// ----------------------------------------------------------------------------
// HDLC framer package
// Types and constants shared by the framer's modules: item kinds, the line
// state that the bit encoder carries from byte to byte, and the result beat.
// ----------------------------------------------------------------------------
package hdlcf_pkg;

   localparam int ByteBits      = 8;
   localparam int StuffRun      = 5;
   localparam int QueueDepth    = 4;
   localparam int QueuePtrBits  = $clog2(QueueDepth);
   localparam int QueueCntBits  = $clog2(QueueDepth + 1);

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [15:0] FCS_INIT  = 16'hFFFF;
   localparam logic [15:0] FCS_POLY  = 16'h8408;

   typedef enum logic [2:0] {
      KIND_START = 3'd0,
      KIND_FLAG  = 3'd1,
      KIND_DATA  = 3'd2,
      KIND_ADDR  = 3'd3,
      KIND_FCS   = 3'd4,
      KIND_FLUSH = 3'd5
   } kind_type;

   // Line state carried between bytes: NRZI level, partial output byte,
   // number of bits in it, and the current run of ones.
   typedef struct packed {
      logic       level;
      logic [7:0] shift;
      logic [2:0] bitcnt;
      logic [2:0] ones;
   } line_state_type;

   // Up to two finished output bytes from one encoded input byte.
   typedef struct packed {
      logic [1:0] cnt;
      logic [7:0] data0;
      logic [7:0] data1;
   } enc_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } beat_type;

   typedef struct packed {
      logic [1:0] cnt;
      beat_type   beat0;
      beat_type   beat1;
   } push_type;

endpackage

// File: rtl/hdlc_bit_stuff_nrzi_framer.sv
// ----------------------------------------------------------------------------
// HDLC bit-stuffing NRZI framer
// An accepted item is held in the item register; its bytes go into the result
// queue once it has room and are offered from there. Throughput: one item per
// cycle (FCS items take a pass per byte) while the result queue has room; the
// result channel drains at most one byte per cycle, so the byte output rate
// bounds the item rate.
// Reset clears the line state, sets the FCS to all ones and empties the queue.
// ----------------------------------------------------------------------------
module hdlc_bit_stuff_nrzi_framer
   import hdlcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_address,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   function automatic logic [15:0] fcs_step(input logic [15:0] fcs, input logic [7:0] b);
      logic [15:0] c;
      c = fcs ^ {8'h00, b};
      for (int i = 0; i < ByteBits; i++) begin
         c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Input item register.
   logic           item_valid_ff;
   logic [2:0]     kind_ff;
   logic [7:0]     byte_ff;
   logic           eoa_ff;
   logic           phase_ff, phase_in;

   // Framing state.
   line_state_type st_ff, st_in;
   logic [15:0]    fcs_ff, fcs_in;

   line_state_type enc_state;
   enc_result_type enc_res;
   logic [7:0]     enc_byte;
   logic           enc_stuff;
   logic [7:0]     addr_byte;
   logic [15:0]    fcs_out;
   logic [3:0]     pad_amt;

   push_type       push;
   logic           has_room;
   logic           pass_go;
   logic           pass_final;
   logic           pass_done;
   logic           req_fire;

   assign req_fire  = req_valid && req_ready;
   assign pass_go   = item_valid_ff && has_room;
   assign pass_done = pass_go && pass_final;
   assign req_ready = !item_valid_ff || pass_done;

   assign addr_byte = {byte_ff[6:0], eoa_ff};
   assign fcs_out   = ~fcs_ff;
   assign pad_amt   = 4'(ByteBits) - {1'b0, st_ff.bitcnt};

   always_comb begin
      enc_stuff = 1'b1;
      case (kind_ff)
         KIND_FLAG: begin
            enc_byte  = FLAG_BYTE;
            enc_stuff = 1'b0;
         end
         KIND_ADDR: enc_byte = addr_byte;
         KIND_FCS:  enc_byte = phase_ff ? fcs_out[15:8] : fcs_out[7:0];
         default:   enc_byte = byte_ff;
      endcase
   end

   hdlcf_bit_enc u_bit_enc (
      .state_in  (st_ff),
      .data_in   (enc_byte),
      .stuff_en  (enc_stuff),
      .state_out (enc_state),
      .result    (enc_res)
   );

   always_comb begin
      beat_type b0;
      beat_type b1;
      st_in      = st_ff;
      fcs_in     = fcs_ff;
      phase_in   = phase_ff;
      pass_final = 1'b1;
      b0         = '{data: enc_res.data0, last: 1'b0};
      b1         = '{data: enc_res.data1, last: 1'b0};
      push       = '0;
      case (kind_ff)
         KIND_START: begin
            st_in  = '0;
            fcs_in = FCS_INIT;
         end
         KIND_FLAG: begin
            st_in    = enc_state;
            push.cnt = enc_res.cnt;
         end
         KIND_DATA: begin
            st_in    = enc_state;
            fcs_in   = fcs_step(fcs_ff, byte_ff);
            push.cnt = enc_res.cnt;
         end
         KIND_ADDR: begin
            st_in    = enc_state;
            fcs_in   = fcs_step(fcs_ff, addr_byte);
            push.cnt = enc_res.cnt;
         end
         KIND_FCS: begin
            // Low byte on the first pass, high byte on the second.
            st_in      = enc_state;
            push.cnt   = enc_res.cnt;
            pass_final = phase_ff;
            phase_in   = ~phase_ff;
         end
         KIND_FLUSH: begin
            if (st_ff.bitcnt != 3'd0) begin
               b0           = '{data: 8'(st_ff.shift << pad_amt), last: 1'b0};
               push.cnt     = 2'd1;
               st_in.shift  = '0;
               st_in.bitcnt = '0;
            end
         end
         default: ;
      endcase
      if (pass_final) begin
         if (push.cnt == 2'd2) b1.last = 1'b1;
         else b0.last = 1'b1;
      end
      push.beat0 = b0;
      push.beat1 = b1;
      if (!pass_go) begin
         push.cnt = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
         st_ff         <= '0;
         fcs_ff        <= FCS_INIT;
      end else begin
         if (req_fire) begin
            item_valid_ff <= 1'b1;
            phase_ff      <= 1'b0;
         end else if (pass_done) begin
            item_valid_ff <= 1'b0;
         end
         if (pass_go) begin
            st_ff  <= st_in;
            fcs_ff <= fcs_in;
            if (!req_fire) phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_kind;
         byte_ff <= req_in_byte;
         eoa_ff  <= req_end_of_address;
      end
   end

   hdlcf_out_queue u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .has_room     (has_room),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// File: rtl/hdlcf_bit_enc.sv
// ----------------------------------------------------------------------------
// HDLC framer bit encoder
// Sends one byte LSB first with optional zero stuffing after five ones,
// NRZI codes every line bit and packs line bits MSB first into bytes.
// ----------------------------------------------------------------------------
module hdlcf_bit_enc
   import hdlcf_pkg::*;
(
   input  line_state_type state_in,
   input  logic [7:0]     data_in,
   input  logic           stuff_en,
   output line_state_type state_out,
   output enc_result_type result
);

   function automatic line_state_type line_bit(input line_state_type s, input logic b);
      line_state_type r;
      r        = s;
      r.level  = b ? s.level : ~s.level;
      r.shift  = {s.shift[6:0], r.level};
      r.bitcnt = s.bitcnt + 3'd1;
      return r;
   endfunction

   always_comb begin
      line_state_type s;
      enc_result_type r;
      logic           b;
      s = state_in;
      r = '0;
      for (int i = 0; i < ByteBits; i++) begin
         b = data_in[i];
         s = line_bit(s, b);
         // The bit count wraps to zero exactly when a line byte is complete.
         if (s.bitcnt == 3'd0) begin
            if (r.cnt == 2'd0) r.data0 = s.shift;
            else r.data1 = s.shift;
            r.cnt = r.cnt + 2'd1;
         end
         if (b) begin
            if (s.ones != 3'd7) s.ones = s.ones + 3'd1;
            if (stuff_en && s.ones == 3'(StuffRun)) begin
               s = line_bit(s, 1'b0);
               if (s.bitcnt == 3'd0) begin
                  if (r.cnt == 2'd0) r.data0 = s.shift;
                  else r.data1 = s.shift;
                  r.cnt = r.cnt + 2'd1;
               end
               s.ones = 3'd0;
            end
         end else begin
            s.ones = 3'd0;
         end
      end
      state_out = s;
      result    = r;
   end

endmodule

// File: rtl/hdlcf_out_queue.sv
// ----------------------------------------------------------------------------
// HDLC framer result queue
// Small register queue that takes up to two bytes a cycle from the encoder
// and hands one beat a cycle to the result channel while it is ready.
// ----------------------------------------------------------------------------
module hdlcf_out_queue
   import hdlcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       has_room,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   beat_type                  entry_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueueCntBits-1:0]   count_ff, count_in;
   logic                      pop;
   logic [QueuePtrBits-1:0]   wr_ptr_next;

   assign rsp_valid    = count_ff != '0;
   assign rsp_out_byte = entry_ff[rd_ptr_ff].data;
   assign rsp_last     = entry_ff[rd_ptr_ff].last;
   assign pop          = rsp_valid && rsp_ready;
   // Room for a full two-byte push, not counting this cycle's pop.
   assign has_room     = count_ff <= QueueCntBits'(QueueDepth - 2);
   assign wr_ptr_next  = wr_ptr_ff + QueuePtrBits'(1);

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrBits'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + QueuePtrBits'(push.cnt);
      count_in  = count_ff + QueueCntBits'(push.cnt) - QueueCntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) entry_ff[wr_ptr_ff] <= push.beat0;
      if (push.cnt == 2'd2) entry_ff[wr_ptr_next] <= push.beat1;
   end

endmodule

// File: rtl/hdlcf_checker.sv
// ----------------------------------------------------------------------------
// HDLC framer port checker
// Watches the framer's ports for reset behavior and result channel rules.
// ----------------------------------------------------------------------------
module hdlcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // Reset empties the result queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

   // Reset empties the item register, so a new beat can be taken.
   assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready right after reset");

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("result payload changed while stalled");

endmodule

bind hdlc_bit_stuff_nrzi_framer hdlcf_checker u_hdlcf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last)
);

// File: sim/hdlc_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HDLC framer checker
// Watches the item and result channels of the framer. Every accepted item is
// run through a bit-level model of the stuffing and NRZI line coder. Every
// accepted result beat is compared with the oldest predicted line byte.
// ----------------------------------------------------------------------------
module hdlc_frame_checker
   import hdlcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_address,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending_count,
   output int         checked_count
);

   beat_type   expected_line_bytes[$];
   beat_type   item_bytes[3];
   int         item_nbytes;

   logic       line_lvl;
   logic [7:0] line_shift;
   int         line_nbits;
   int         ones_seen;
   logic [15:0] crc_acc;

   int         n_fail;
   int         n_checked;

   task automatic clear_line();
      line_lvl   = 1'b0;
      line_shift = 8'h00;
      line_nbits = 0;
      ones_seen  = 0;
      crc_acc    = FCS_INIT;
   endtask

   task automatic keep_line_byte(input logic [7:0] b);
      if (item_nbytes < 3) begin
         item_bytes[item_nbytes].data = b;
         item_bytes[item_nbytes].last = 1'b0;
         item_nbytes++;
      end
   endtask

   // A zero on the line toggles the level; the level is what gets shifted in.
   task automatic put_line_bit(input logic b);
      if (!b)
         line_lvl = ~line_lvl;
      line_shift = {line_shift[6:0], line_lvl};
      line_nbits++;
      if (line_nbits >= ByteBits) begin
         line_nbits = 0;
         keep_line_byte(line_shift);
      end
   endtask

   task automatic put_byte_lsb_first(input logic [7:0] b, input logic stuff);
      for (int i = 0; i < ByteBits; i++) begin
         put_line_bit(b[i]);
         if (b[i]) begin
            if (ones_seen < 7)
               ones_seen++;
            if (stuff && ones_seen == StuffRun) begin
               put_line_bit(1'b0);
               ones_seen = 0;
            end
         end else begin
            ones_seen = 0;
         end
      end
   endtask

   task automatic crc_add_byte(input logic [7:0] b);
      logic [15:0] c;
      c = crc_acc ^ {8'h00, b};
      for (int i = 0; i < ByteBits; i++)
         c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
      crc_acc = c;
   endtask

   task automatic encode_item(input logic [2:0] kind, input logic [7:0] byte_in,
                              input logic eoa);
      logic [7:0]  b;
      logic [15:0] fcs_out;
      item_nbytes = 0;
      case (kind)
         KIND_START: clear_line();
         KIND_FLAG:  put_byte_lsb_first(FLAG_BYTE, 1'b0);
         KIND_DATA: begin
            crc_add_byte(byte_in);
            put_byte_lsb_first(byte_in, 1'b1);
         end
         KIND_ADDR: begin
            b = {byte_in[6:0], eoa};
            crc_add_byte(b);
            put_byte_lsb_first(b, 1'b1);
         end
         KIND_FCS: begin
            fcs_out = crc_acc ^ 16'hFFFF;
            put_byte_lsb_first(fcs_out[7:0], 1'b1);
            put_byte_lsb_first(fcs_out[15:8], 1'b1);
         end
         KIND_FLUSH: begin
            if (line_nbits != 0) begin
               b = line_shift << (ByteBits - line_nbits);
               keep_line_byte(b);
               line_shift = 8'h00;
               line_nbits = 0;
            end
         end
         default: ;
      endcase
      if (item_nbytes > 0)
         item_bytes[item_nbytes - 1].last = 1'b1;
      for (int i = 0; i < item_nbytes; i++)
         expected_line_bytes.push_back(item_bytes[i]);
   endtask

   initial begin
      n_fail    = 0;
      n_checked = 0;
      clear_line();
   end

   always @(posedge clock) begin
      beat_type want;
      if (reset) begin
         clear_line();
         expected_line_bytes.delete();
      end else begin
         if (req_valid && req_ready)
            encode_item(req_kind, req_in_byte, req_end_of_address);
         if (rsp_valid && rsp_ready) begin
            if (expected_line_bytes.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                        $time, rsp_out_byte, rsp_last);
               n_fail++;
            end else begin
               want = expected_line_bytes.pop_front();
               n_checked++;
               if (rsp_out_byte !== want.data) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.data, rsp_out_byte);
                  n_fail++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b",
                           $time, want.last, rsp_last);
                  n_fail++;
               end
            end
         end
      end
      fail_count    <= n_fail;
      pending_count <= expected_line_bytes.size();
      checked_count <= n_checked;
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HDLC framer testbench
// Drives directed corner items and then random frames (mostly well formed,
// some broken, some noise) into the framer under three idling mixes and one
// long result stall. The checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
   import hdlcf_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int ItemTarget  = 500;
   localparam int StallCycles = 400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_kind = KIND_START;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_address = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   int fail_count;
   int pending_count;
   int checked_count;

   int send_idle_pct = 31;
   int recv_idle_pct = 76;
   int items_sent    = 0;
   int frames_sent   = 0;
   int stall_seq     = 0;
   int cycle_count   = 0;

   hdlc_bit_stuff_nrzi_framer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_in_byte        (req_in_byte),
      .req_end_of_address (req_end_of_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last)
   );

   hdlc_frame_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_in_byte        (req_in_byte),
      .req_end_of_address (req_end_of_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: random back-pressure, plus a long hold-off on request.
   always @(posedge clock) begin
      int stall_seen;
      int hold_left;
      if (stall_seq != stall_seen) begin
         stall_seen = stall_seq;
         hold_left  = StallCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Valid stays high from one beat to the next unless an idle cycle is drawn.
   task automatic send_item(input logic [2:0] kind, input logic [7:0] b, input logic eoa);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_in_byte        <= b;
      req_end_of_address <= eoa;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Runs of ones are favored so that stuffing happens often.
   function automatic logic [7:0] pick_payload_byte();
      int r;
      r = $urandom_range(99);
      if (r < 25)
         return 8'hFF;
      if (r < 35)
         return 8'h00;
      if (r < 45)
         return 8'hF8 | 8'($urandom_range(7));
      return 8'($urandom);
   endfunction

   task automatic send_frame();
      int shape;
      int n_addr;
      int n_data;
      logic [2:0] k;
      shape = $urandom_range(99);
      frames_sent++;
      if (shape < 85) begin
         // Well formed, with random content; a few lose the closing steps.
         n_addr = $urandom_range(1, 4);
         n_data = $urandom_range(0, 10);
         send_item(KIND_START, 8'($urandom), 1'($urandom));
         repeat ($urandom_range(1, 2))
            send_item(KIND_FLAG, 8'($urandom), 1'($urandom));
         for (int i = 0; i < n_addr; i++)
            send_item(KIND_ADDR, pick_payload_byte(), (i == n_addr - 1));
         for (int i = 0; i < n_data; i++)
            send_item(KIND_DATA, pick_payload_byte(), 1'($urandom));
         if (shape < 78) begin
            send_item(KIND_FCS, 8'($urandom), 1'($urandom));
            send_item(KIND_FLAG, 8'($urandom), 1'($urandom));
         end
         if ($urandom_range(99) < 60)
            send_item(KIND_FLUSH, 8'($urandom), 1'($urandom));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            k = 3'($urandom_range(0, 7));
            send_item(k, pick_payload_byte(), 1'($urandom));
         end
      end
   endtask

   initial begin
      bit stalled;
      stalled = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: field extremes, every kind, flush with and without a
      // partial byte, long ones runs across bytes, and the unused kinds.
      send_item(KIND_START, 8'hFF, 1'b1);
      send_item(KIND_FLAG, 8'h00, 1'b0);
      send_item(KIND_ADDR, 8'hFF, 1'b0);
      send_item(KIND_ADDR, 8'h00, 1'b0);
      send_item(KIND_ADDR, 8'h80, 1'b1);
      send_item(KIND_DATA, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'hFF, 1'b1);
      send_item(KIND_DATA, 8'hFF, 1'b0);
      send_item(KIND_DATA, 8'h7E, 1'b0);
      send_item(KIND_FCS, 8'h00, 1'b0);
      send_item(KIND_FLAG, 8'hFF, 1'b1);
      send_item(KIND_FLUSH, 8'h00, 1'b0);
      send_item(KIND_FLUSH, 8'hFF, 1'b1);
      send_item(3'd6, 8'hFF, 1'b1);
      send_item(3'd7, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'h1F, 1'b0);
      send_item(KIND_FLUSH, 8'h00, 1'b0);
      send_item(KIND_START, 8'h00, 1'b0);
      send_item(KIND_FCS, 8'hFF, 1'b1);
      send_item(KIND_FLUSH, 8'h00, 1'b0);
      send_item(KIND_START, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'hFF, 1'b0);
      send_item(KIND_FLAG, 8'h00, 1'b0);
      send_item(KIND_FLUSH, 8'h00, 1'b0);

      while (items_sent < ItemTarget) begin
         if (items_sent < 200) begin
            send_idle_pct = 31;
            recv_idle_pct = 76;
         end else if (items_sent < 375) begin
            send_idle_pct = 76;
            recv_idle_pct = 31;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            if (!stalled) begin
               stalled = 1'b1;
               stall_seq++;
            end
         end
         send_frame();
      end
      req_valid <= 1'b0;

      while (pending_count != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d items in %0d frames or noise bursts; checked %0d line bytes.",
               items_sent, frames_sent, checked_count);
      $display("Mismatches: %0d, beats still expected: %0d.", fail_count, pending_count);
      if (fail_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
